// File: rtl/mct_pkg.sv
package mct_pkg;

	localparam int COORD_W = 10;

	localparam logic [8:0]  WIDTH_RST  = 9'd256;
	localparam logic [8:0]  HEIGHT_RST = 9'd256;
	localparam logic [15:0] LIMIT_RST  = 16'd10000;

	typedef logic [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_START = 2'd1,
		CMD_STEP  = 2'd2
	} cmd_t;

	typedef enum logic [2:0] {
		STS_POINT     = 3'd0,
		STS_CLOSED    = 3'd1,
		STS_LIMIT     = 3'd2,
		STS_NO_OBJECT = 3'd3,
		STS_IDLE      = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		CFG_WIDTH  = 2'd0,
		CFG_HEIGHT = 2'd1,
		CFG_LIMIT  = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		S_IDLE      = 4'd0,
		S_DISPATCH  = 4'd1,
		S_WR_MUL    = 4'd2,
		S_WR_STORE  = 4'd3,
		S_SCAN_RD   = 4'd4,
		S_SCAN_TEST = 4'd5,
		S_WALK_CHK  = 4'd6,
		S_WALK_RD   = 4'd7,
		S_WALK_TEST = 4'd8,
		S_CLEAR     = 4'd9
	} step_t;

	typedef enum logic [3:0] {
		OP_NOP       = 4'd0,
		OP_DISPATCH  = 4'd1,
		OP_WR_MUL    = 4'd2,
		OP_WR_STORE  = 4'd3,
		OP_SCAN_RD   = 4'd4,
		OP_SCAN_TEST = 4'd5,
		OP_WALK_CHK  = 4'd6,
		OP_WALK_RD   = 4'd7,
		OP_WALK_TEST = 4'd8,
		OP_CLEAR     = 4'd9
	} op_t;

	typedef enum logic [2:0] {
		J_NEXT     = 3'd0,
		J_GOTO     = 3'd1,
		J_WAIT_IN  = 3'd2,
		J_DISPATCH = 3'd3,
		J_COND     = 3'd4
	} jmp_t;

	typedef struct packed {
		op_t   op;
		jmp_t  jmp;
		logic  needs_out;
		step_t target;
	} ctrl_t;

	// Control store. A conditional jump goes to idle when the step finishes the command,
	// to the following step when it advances, and to the target otherwise.
	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		case (s)
			S_IDLE:      c = '{OP_NOP,       J_WAIT_IN,  1'b0, S_IDLE};
			S_DISPATCH:  c = '{OP_DISPATCH,  J_DISPATCH, 1'b1, S_IDLE};
			S_WR_MUL:    c = '{OP_WR_MUL,    J_NEXT,     1'b0, S_IDLE};
			S_WR_STORE:  c = '{OP_WR_STORE,  J_GOTO,     1'b0, S_IDLE};
			S_SCAN_RD:   c = '{OP_SCAN_RD,   J_NEXT,     1'b0, S_IDLE};
			S_SCAN_TEST: c = '{OP_SCAN_TEST, J_COND,     1'b1, S_SCAN_RD};
			S_WALK_CHK:  c = '{OP_WALK_CHK,  J_COND,     1'b1, S_IDLE};
			S_WALK_RD:   c = '{OP_WALK_RD,   J_NEXT,     1'b0, S_IDLE};
			S_WALK_TEST: c = '{OP_WALK_TEST, J_COND,     1'b1, S_WALK_CHK};
			S_CLEAR:     c = '{OP_CLEAR,     J_COND,     1'b0, S_CLEAR};
			default:     c = '{OP_NOP,       J_GOTO,     1'b0, S_IDLE};
		endcase
		return c;
	endfunction

	// Ring index that follows the probe's place around the anchor.
	function automatic logic [2:0] ring_next(input logic signed [10:0] dc,
			input logic signed [10:0] dr);
		logic [2:0] n;
		n = 3'd0;
		if (dc >= -11'sd1 && dc <= 11'sd1 && dr >= -11'sd1 && dr <= 11'sd1) begin
			case ({dc[1:0], dr[1:0]})
				4'b1111: n = 3'd2;
				4'b1100: n = 3'd3;
				4'b1101: n = 3'd4;
				4'b0011: n = 3'd1;
				4'b0001: n = 3'd5;
				4'b0111: n = 3'd0;
				4'b0100: n = 3'd7;
				4'b0101: n = 3'd6;
				default: n = 3'd0;
			endcase
		end
		return n;
	endfunction

	function automatic coord_t ring_dcol(input logic [2:0] n);
		coord_t d;
		case (n)
			3'd1, 3'd2, 3'd3: d = '1;
			3'd5, 3'd6, 3'd7: d = coord_t'(1);
			default:          d = '0;
		endcase
		return d;
	endfunction

	function automatic coord_t ring_drow(input logic [2:0] n);
		coord_t d;
		case (n)
			3'd0, 3'd1, 3'd7: d = '1;
			3'd3, 3'd4, 3'd5: d = coord_t'(1);
			default:          d = '0;
		endcase
		return d;
	endfunction

endpackage

// File: rtl/moore_contour_tracer.sv
// Channel   Handshake               Payload
// command   cmd_valid / cmd_ready   command, pixel_x, pixel_y, pixel_on
// result    res_valid / res_ready   status, point_x, point_y, point_index
// config    cfg_write               cfg_index, cfg_data
//
// A pixel write runs dispatch, address multiply and store before the next transfer.
// A start dispatches, reads and tests each scanned pixel, then walks like a step command.
// A step dispatches, then runs each probe as address multiply, map read and test, and ends
// at a check on closure or the limit; a trace's probes are bounded only by probe_limit.
// After reset the map is cleared one entry a cycle, all IMG_W*IMG_H entries, with cmd_ready low.
// A full result register holds the sequencer at its next result step.
module moore_contour_tracer #(
	parameter int IMG_W = 256,
	parameter int IMG_H = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic        pixel_on,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [2:0]  status,
	output logic [7:0]  point_x,
	output logic [7:0]  point_y,
	output logic [15:0] point_index,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import mct_pkg::*;

	localparam int DEPTH  = IMG_W * IMG_H;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CW_W   = $clog2(IMG_W + 1);
	localparam int CH_W   = $clog2(IMG_H + 1);
	localparam int COL_W  = $clog2(IMG_W);
	localparam int ROW_W  = $clog2(IMG_H);
	localparam int KW0    = (CW_W > CH_W) ? CW_W : CH_W;
	localparam int KW     = (KW0 > COORD_W) ? KW0 : COORD_W;
	localparam int MUL_W  = 9 + CW_W;

	step_t pc_q, pc_d;
	ctrl_t cw;
	logic  stall, go, finish, advance;

	logic [1:0] cmd_q;
	logic [7:0] wx_q, wy_q;
	logic       won_q;

	logic [8:0]  active_width_q, active_height_q;
	logic [15:0] probe_limit_q;

	logic [ADDR_W-1:0] scan_addr_q;
	logic [COL_W-1:0]  scan_col_q;
	logic [ROW_W-1:0]  scan_row_q;
	coord_t            probe_col_q, probe_row_q, back_col_q, back_row_q;
	logic [7:0]        start_col_q, start_row_q, anchor_col_q, anchor_row_q;
	logic [15:0]       probe_cnt_q, pts_q;
	logic              tracing_q;
	logic [MUL_W-1:0]  prod_q;
	logic              inb_q;
	logic              rd_q;

	logic map_mem [DEPTH];

	logic              mem_we, mem_re, mem_wd;
	logic [ADDR_W-1:0] mem_addr;

	logic       res_valid_q;
	status_t    status_q;
	logic [7:0] px_q, py_q;
	logic [15:0] idx_q;

	logic [KW-1:0]     aw_k, ah_k, eff_w_k, eff_h_k;
	logic [CW_W-1:0]   eff_w;
	logic              inb_probe, inb_pix, scan_end, close, limit_hit, hit;
	logic [15:0]       lim;
	logic [8:0]        mul_row, addr_col;
	logic [MUL_W-1:0]  mul_res, addr_sum;
	logic [ADDR_W-1:0] probe_addr;
	logic [7:0]        scan_col8, scan_row8;
	logic signed [10:0] dc, dr;
	logic [2:0]        nidx;
	coord_t            adv_col, adv_row;
	logic              emit;
	status_t           emit_status;
	logic [7:0]        emit_x, emit_y;
	logic [15:0]       emit_idx;

	assign cw        = ucode(pc_q);
	assign stall     = cw.needs_out && res_valid_q && !res_ready;
	assign go        = !stall;
	assign cmd_ready = (pc_q == S_IDLE);

	assign res_valid   = res_valid_q;
	assign status      = status_q;
	assign point_x     = px_q;
	assign point_y     = py_q;
	assign point_index = idx_q;

	// Sizes in use, clamped to the array; a zero size counts as one.
	assign aw_k    = KW'(active_width_q);
	assign ah_k    = KW'(active_height_q);
	assign eff_w_k = (aw_k == '0) ? KW'(1) : ((aw_k > KW'(IMG_W)) ? KW'(IMG_W) : aw_k);
	assign eff_h_k = (ah_k == '0) ? KW'(1) : ((ah_k > KW'(IMG_H)) ? KW'(IMG_H) : ah_k);
	assign eff_w   = CW_W'(eff_w_k);

	assign inb_probe = !probe_col_q[COORD_W-1] && !probe_row_q[COORD_W-1]
		&& (KW'(probe_col_q[8:0]) < eff_w_k) && (KW'(probe_row_q[8:0]) < eff_h_k);
	assign inb_pix   = (KW'(wx_q) < eff_w_k) && (KW'(wy_q) < eff_h_k);

	assign mul_row    = (cw.op == OP_WR_MUL) ? 9'(wy_q) : probe_row_q[8:0];
	assign mul_res    = MUL_W'(mul_row) * MUL_W'(eff_w);
	assign addr_col   = (cw.op == OP_WR_STORE) ? 9'(wx_q) : probe_col_q[8:0];
	assign addr_sum   = prod_q + MUL_W'(addr_col);
	assign probe_addr = ADDR_W'(addr_sum);

	assign scan_end  = (KW'(scan_col_q) == eff_w_k - KW'(1))
		&& (KW'(scan_row_q) == eff_h_k - KW'(1));
	assign scan_col8 = 8'(scan_col_q);
	assign scan_row8 = 8'(scan_row_q);

	assign close     = (probe_col_q == {2'b00, start_col_q})
		&& (probe_row_q == {2'b00, start_row_q}) && (probe_cnt_q != 16'd0);
	assign lim       = (probe_limit_q == 16'd0) ? 16'd1 : probe_limit_q;
	assign limit_hit = (probe_cnt_q >= lim);
	assign hit       = inb_q && rd_q;

	assign dc      = $signed({probe_col_q[COORD_W-1], probe_col_q})
		- $signed({3'b000, anchor_col_q});
	assign dr      = $signed({probe_row_q[COORD_W-1], probe_row_q})
		- $signed({3'b000, anchor_row_q});
	assign nidx    = ring_next(dc, dr);
	assign adv_col = {2'b00, anchor_col_q} + ring_dcol(nidx);
	assign adv_row = {2'b00, anchor_row_q} + ring_drow(nidx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= S_CLEAR;
		end else begin
			pc_q <= pc_d;
		end
	end

	always_comb begin
		finish  = 1'b0;
		advance = 1'b0;
		case (cw.op)
			OP_SCAN_TEST: begin
				advance = rd_q;
				finish  = !rd_q && scan_end;
			end
			OP_WALK_CHK: begin
				finish  = close || limit_hit;
				advance = 1'b1;
			end
			OP_WALK_TEST: finish = hit;
			OP_CLEAR:     finish = (scan_addr_q == ADDR_W'(DEPTH - 1));
			default: ;
		endcase

		pc_d = pc_q;
		if (!stall) begin
			case (cw.jmp)
				J_NEXT:    pc_d = step_t'(pc_q + 4'd1);
				J_GOTO:    pc_d = cw.target;
				J_WAIT_IN: pc_d = cmd_valid ? step_t'(pc_q + 4'd1) : pc_q;
				J_DISPATCH: begin
					case (cmd_t'(cmd_q))
						CMD_WRITE: pc_d = S_WR_MUL;
						CMD_START: pc_d = S_SCAN_RD;
						CMD_STEP:  pc_d = tracing_q ? S_WALK_CHK : S_IDLE;
						default:   pc_d = S_IDLE;
					endcase
				end
				J_COND: begin
					if (finish) begin
						pc_d = S_IDLE;
					end else if (advance) begin
						pc_d = step_t'(pc_q + 4'd1);
					end else begin
						pc_d = cw.target;
					end
				end
				default: pc_d = S_IDLE;
			endcase
		end
	end

	always_comb begin
		emit        = 1'b0;
		emit_status = STS_POINT;
		emit_x      = 8'd0;
		emit_y      = 8'd0;
		emit_idx    = 16'd0;
		case (cw.op)
			OP_DISPATCH: begin
				emit        = (cmd_t'(cmd_q) == CMD_STEP) && !tracing_q;
				emit_status = STS_IDLE;
			end
			OP_SCAN_TEST: begin
				emit        = !rd_q && scan_end;
				emit_status = STS_NO_OBJECT;
			end
			OP_WALK_CHK: begin
				emit        = close || limit_hit;
				emit_status = close ? STS_CLOSED : STS_LIMIT;
			end
			OP_WALK_TEST: begin
				emit     = hit;
				emit_x   = probe_col_q[7:0];
				emit_y   = probe_row_q[7:0];
				emit_idx = pts_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		mem_we   = 1'b0;
		mem_re   = 1'b0;
		mem_wd   = 1'b0;
		mem_addr = scan_addr_q;
		case (cw.op)
			OP_WR_STORE: begin
				mem_we   = inb_q;
				mem_wd   = won_q;
				mem_addr = probe_addr;
			end
			OP_SCAN_RD: mem_re = 1'b1;
			OP_WALK_RD: begin
				mem_re   = inb_q;
				mem_addr = probe_addr;
			end
			OP_CLEAR: mem_we = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			map_mem[mem_addr] <= mem_wd;
		end
		if (mem_re) begin
			rd_q <= map_mem[mem_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= command;
			wx_q  <= pixel_x;
			wy_q  <= pixel_y;
			won_q <= pixel_on;
		end
		if (go && (cw.op == OP_WR_MUL || cw.op == OP_WALK_CHK)) begin
			prod_q <= mul_res;
			inb_q  <= (cw.op == OP_WR_MUL) ? inb_pix : inb_probe;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_width_q  <= WIDTH_RST;
			active_height_q <= HEIGHT_RST;
			probe_limit_q   <= LIMIT_RST;
			scan_addr_q     <= '0;
			scan_col_q      <= '0;
			scan_row_q      <= '0;
			probe_col_q     <= '0;
			probe_row_q     <= '0;
			back_col_q      <= '0;
			back_row_q      <= '0;
			start_col_q     <= '0;
			start_row_q     <= '0;
			anchor_col_q    <= '0;
			anchor_row_q    <= '0;
			probe_cnt_q     <= '0;
			pts_q           <= '0;
			tracing_q       <= 1'b0;
			res_valid_q     <= 1'b0;
			status_q        <= STS_POINT;
			px_q            <= '0;
			py_q            <= '0;
			idx_q           <= '0;
		end else begin
			if (cfg_write) begin
				case (cfg_reg_t'(cfg_index))
					CFG_WIDTH:  active_width_q  <= cfg_data[8:0];
					CFG_HEIGHT: active_height_q <= cfg_data[8:0];
					CFG_LIMIT:  probe_limit_q   <= cfg_data;
					default: ;
				endcase
			end

			if (go && emit) begin
				res_valid_q <= 1'b1;
				status_q    <= emit_status;
				px_q        <= emit_x;
				py_q        <= emit_y;
				idx_q       <= emit_idx;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			if (go) begin
				case (cw.op)
					OP_DISPATCH: begin
						if (cmd_t'(cmd_q) == CMD_START) begin
							scan_addr_q <= '0;
							scan_col_q  <= '0;
							scan_row_q  <= '0;
						end
					end
					OP_SCAN_TEST: begin
						if (rd_q) begin
							start_col_q  <= scan_col8;
							start_row_q  <= scan_row8;
							anchor_col_q <= scan_col8;
							anchor_row_q <= scan_row8;
							probe_col_q  <= {2'b00, scan_col8};
							probe_row_q  <= {2'b00, scan_row8};
							back_col_q   <= {2'b00, scan_col8};
							back_row_q   <= {2'b00, scan_row8} - coord_t'(1);
							probe_cnt_q  <= '0;
							pts_q        <= '0;
							tracing_q    <= 1'b1;
						end else if (scan_end) begin
							tracing_q <= 1'b0;
						end else begin
							scan_addr_q <= scan_addr_q + ADDR_W'(1);
							if (KW'(scan_col_q) == eff_w_k - KW'(1)) begin
								scan_col_q <= '0;
								scan_row_q <= scan_row_q + ROW_W'(1);
							end else begin
								scan_col_q <= scan_col_q + COL_W'(1);
							end
						end
					end
					OP_WALK_CHK: begin
						if (close || limit_hit) begin
							tracing_q <= 1'b0;
						end else begin
							probe_cnt_q <= probe_cnt_q + 16'd1;
						end
					end
					OP_WALK_TEST: begin
						if (hit) begin
							anchor_col_q <= probe_col_q[7:0];
							anchor_row_q <= probe_row_q[7:0];
							pts_q        <= pts_q + 16'd1;
							probe_col_q  <= back_col_q;
							probe_row_q  <= back_row_q;
						end else begin
							back_col_q  <= probe_col_q;
							back_row_q  <= probe_row_q;
							probe_col_q <= adv_col;
							probe_row_q <= adv_row;
						end
					end
					OP_CLEAR: scan_addr_q <= scan_addr_q + ADDR_W'(1);
					default: ;
				endcase
			end
		end
	end

endmodule

// File: sim/contour_checker.sv
module contour_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	input  logic        cmd_ready,
	input  logic [1:0]  command,
	input  logic [7:0]  pixel_x,
	input  logic [7:0]  pixel_y,
	input  logic        pixel_on,
	input  logic        res_valid,
	input  logic        res_ready,
	input  logic [2:0]  status,
	input  logic [7:0]  point_x,
	input  logic [7:0]  point_y,
	input  logic [15:0] point_index,
	input  logic        cfg_write,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	output int          fail_count,
	output int          pending
);
	import mct_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MAP_W = 256;
	localparam int MAP_H = 256;
	localparam int MAP_CELLS = MAP_W * MAP_H;
	localparam int WANT_DEPTH = 16;

	typedef struct packed {
		status_t     sts;
		logic [7:0]  px;
		logic [7:0]  py;
		logic [15:0] idx;
	} contour_point_t;

	bit obj_map [0:MAP_CELLS-1];
	logic [8:0] img_w;
	logic [8:0] img_h;
	logic [15:0] limit_reg;
	logic [7:0] seed_col, seed_row, anchor_col, anchor_row;
	logic signed [9:0] probe_col, probe_row, back_col, back_row;
	logic [15:0] probes_used, points_out;
	bit tracing;

	contour_point_t want_fifo [WANT_DEPTH];
	logic [3:0] want_rd, want_wr;
	int want_count;
	contour_point_t got, want;
	bit has_result;
	int mismatches = 0;

	function automatic int eff_width();
		if (img_w == 9'd0)
			return 1;
		if (img_w > 9'(MAP_W))
			return MAP_W;
		return int'(img_w);
	endfunction

	function automatic int eff_height();
		if (img_h == 9'd0)
			return 1;
		if (img_h > 9'(MAP_H))
			return MAP_H;
		return int'(img_h);
	endfunction

	function automatic bit pixel_on_at(input int c, input int r);
		int w, h;
		w = eff_width();
		h = eff_height();
		if (c < 0 || r < 0 || c >= w || r >= h)
			return 1'b0;
		return obj_map[r * w + c];
	endfunction

	function automatic int ring_col(input int n);
		case (n)
			1, 2, 3: return -1;
			5, 6, 7: return 1;
			default: return 0;
		endcase
	endfunction

	function automatic int ring_row(input int n);
		case (n)
			0, 1, 7: return -1;
			3, 4, 5: return 1;
			default: return 0;
		endcase
	endfunction

	// Ring entry that follows the probe's offset from the anchor; the centre and
	// anything farther away restart the ring at its first entry.
	function automatic int ring_after(input int dc, input int dr);
		if (dc < -1 || dc > 1 || dr < -1 || dr > 1)
			return 0;
		case ((dc + 1) * 3 + (dr + 1))
			0: return 2;
			1: return 3;
			2: return 4;
			3: return 1;
			5: return 5;
			7: return 7;
			8: return 6;
			default: return 0;
		endcase
	endfunction

	task automatic reset_tracer();
		foreach (obj_map[a])
			obj_map[a] = 1'b0;
		img_w = WIDTH_RST;
		img_h = HEIGHT_RST;
		limit_reg = LIMIT_RST;
		seed_col = '0;
		seed_row = '0;
		anchor_col = '0;
		anchor_row = '0;
		probe_col = '0;
		probe_row = '0;
		back_col = '0;
		back_row = '0;
		probes_used = '0;
		points_out = '0;
		tracing = 1'b0;
	endtask

	task automatic walk_contour(output contour_point_t pt);
		int lim, n;
		pt = '0;
		lim = (limit_reg == 16'd0) ? 1 : int'(limit_reg);
		forever begin
			if (int'(probe_col) == int'(seed_col) && int'(probe_row) == int'(seed_row) &&
					probes_used >= 16'd1) begin
				tracing = 1'b0;
				pt.sts = STS_CLOSED;
				return;
			end
			if (probes_used >= lim) begin
				tracing = 1'b0;
				pt.sts = STS_LIMIT;
				return;
			end
			probes_used++;
			if (pixel_on_at(int'(probe_col), int'(probe_row))) begin
				anchor_col = probe_col[7:0];
				anchor_row = probe_row[7:0];
				pt.sts = STS_POINT;
				pt.px = anchor_col;
				pt.py = anchor_row;
				pt.idx = points_out;
				points_out++;
				probe_col = back_col;
				probe_row = back_row;
				return;
			end
			back_col = probe_col;
			back_row = probe_row;
			n = ring_after(int'(probe_col) - int'(anchor_col), int'(probe_row) - int'(anchor_row));
			probe_col = 10'(int'(anchor_col) + ring_col(n));
			probe_row = 10'(int'(anchor_row) + ring_row(n));
		end
	endtask

	task automatic run_command(input logic [1:0] cmd, input logic [7:0] x, input logic [7:0] y,
			input logic on, output bit produces, output contour_point_t pt);
		int w, h, r, c;
		bit found;
		produces = 1'b0;
		pt = '0;
		w = eff_width();
		h = eff_height();
		found = 1'b0;
		case (cmd)
			CMD_WRITE: begin
				if (int'(x) < w && int'(y) < h)
					obj_map[int'(y) * w + int'(x)] = on;
			end
			CMD_START: begin
				produces = 1'b1;
				for (r = 0; r < h && !found; r++) begin
					for (c = 0; c < w && !found; c++) begin
						if (obj_map[r * w + c]) begin
							seed_col = 8'(c);
							seed_row = 8'(r);
							found = 1'b1;
						end
					end
				end
				if (!found) begin
					tracing = 1'b0;
					pt.sts = STS_NO_OBJECT;
				end else begin
					anchor_col = seed_col;
					anchor_row = seed_row;
					probe_col = 10'(int'(seed_col));
					probe_row = 10'(int'(seed_row));
					back_col = 10'(int'(seed_col));
					back_row = 10'(int'(seed_row) - 1);
					probes_used = '0;
					points_out = '0;
					tracing = 1'b1;
					walk_contour(pt);
				end
			end
			CMD_STEP: begin
				produces = 1'b1;
				if (!tracing)
					pt.sts = STS_IDLE;
				else
					walk_contour(pt);
			end
			default: ;
		endcase
	endtask

	task automatic flag(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reset_tracer();
			want_rd = '0;
			want_wr = '0;
			want_count = 0;
			fail_count <= 0;
			pending <= 0;
		end else begin
			if (res_valid && res_ready) begin
				if (want_count == 0) begin
					flag($sformatf("result transfer with status %0d and nothing expected", status));
				end else begin
					want = want_fifo[want_rd];
					want_rd++;
					want_count--;
					if (status !== want.sts)
						flag($sformatf("status %0d, expected %0d", status, want.sts));
					if (point_x !== want.px)
						flag($sformatf("point_x %0d, expected %0d", point_x, want.px));
					if (point_y !== want.py)
						flag($sformatf("point_y %0d, expected %0d", point_y, want.py));
					if (point_index !== want.idx)
						flag($sformatf("point_index %0d, expected %0d", point_index, want.idx));
				end
			end
			if (cfg_write) begin
				case (cfg_index)
					CFG_WIDTH:  img_w = cfg_data[8:0];
					CFG_HEIGHT: img_h = cfg_data[8:0];
					CFG_LIMIT:  limit_reg = cfg_data;
					default: ;
				endcase
			end
			if (cmd_valid && cmd_ready) begin
				run_command(command, pixel_x, pixel_y, pixel_on, has_result, got);
				if (has_result) begin
					if (want_count == WANT_DEPTH) begin
						flag("more results outstanding than the block can hold");
					end else begin
						want_fifo[want_wr] = got;
						want_wr++;
						want_count++;
					end
				end
			end
			fail_count <= mismatches;
			pending <= want_count;
		end
	end

endmodule

// File: sim/tb.sv
module tb;
	import mct_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 4000000;
	localparam int HOLD_CYCLES = 600;
	localparam int SETTLE_CYCLES = 16;
	localparam int ITEM_TARGET = 1000;
	localparam logic [1:0] CMD_NOISE = 2'd3;

	typedef enum logic [1:0] {
		RX_FREE,
		RX_RANDOM,
		RX_PATTERN,
		RX_SPARSE
	} rx_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cmd_valid = 1'b0;
	logic        cmd_ready;
	logic [1:0]  command = '0;
	logic [7:0]  pixel_x = '0;
	logic [7:0]  pixel_y = '0;
	logic        pixel_on = 1'b0;
	logic        res_valid;
	logic        res_ready = 1'b0;
	logic [2:0]  status;
	logic [7:0]  point_x;
	logic [7:0]  point_y;
	logic [15:0] point_index;
	logic        cfg_write = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int fail_count;
	int pending;

	rx_mode_t rx_mode = RX_RANDOM;
	logic [7:0] stall_pat = 8'b1101_0010;
	logic hold_toggle = 1'b0;
	logic hold_seen = 1'b0;
	int hold_left = 0;
	int cycles = 0;

	int cur_w = 256;
	int cur_h = 256;
	int items = 0;
	int burst_left = 0;
	bit tx_bursty = 1'b1;

	moore_contour_tracer i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_on    (pixel_on),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.status      (status),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_index (point_index),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	contour_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_ready   (cmd_ready),
		.command     (command),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.pixel_on    (pixel_on),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.status      (status),
		.point_x     (point_x),
		.point_y     (point_y),
		.point_index (point_index),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// A toggle of hold_toggle starts a long stretch with the result side stalled.
	always @(posedge clk) begin
		stall_pat <= {stall_pat[6:0], stall_pat[7]};
		if (hold_toggle != hold_seen) begin
			hold_seen <= hold_toggle;
			hold_left <= HOLD_CYCLES;
			res_ready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			res_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_FREE:    res_ready <= 1'b1;
				RX_RANDOM:  res_ready <= ($urandom_range(0, 2) != 0);
				RX_PATTERN: res_ready <= stall_pat[0];
				default:    res_ready <= ($urandom_range(0, 5) == 0);
			endcase
		end
	end

	task automatic send_cmd(input logic [1:0] c, input logic [7:0] x, input logic [7:0] y,
			input logic on);
		int gap;
		gap = 0;
		if (tx_bursty) begin
			if (burst_left == 0) begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 8);
			end
			burst_left--;
		end
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		command <= c;
		pixel_x <= x;
		pixel_y <= y;
		pixel_on <= on;
		do
			@(posedge clk);
		while (!cmd_ready);
		if (c != CMD_NOISE && !(c == CMD_WRITE && (int'(x) >= cur_w || int'(y) >= cur_h)))
			items++;
	endtask

	task automatic settle();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(input logic [15:0] w_data, input logic [15:0] h_data,
			input logic [15:0] lim);
		cfg_write <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_data <= w_data;
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= h_data;
		@(posedge clk);
		cfg_index <= CFG_LIMIT;
		cfg_data <= lim;
		@(posedge clk);
		cfg_write <= 1'b0;
	endtask

	initial begin
		int phase, w, h, x0, y0, rw, rh, xx, yy, pick;
		logic [15:0] w_data, h_data, lim;

		phase = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset sizes and limit: idle step, empty map, lone pixel in the far corner.
		send_cmd(CMD_STEP, 8'h00, 8'h00, 1'b0);
		send_cmd(CMD_START, 8'hFF, 8'hFF, 1'b1);
		send_cmd(CMD_NOISE, 8'hFF, 8'hFF, 1'b1);
		send_cmd(CMD_WRITE, 8'hFF, 8'hFF, 1'b1);
		send_cmd(CMD_START, 8'h00, 8'h00, 1'b0);
		send_cmd(CMD_STEP, 8'hFF, 8'h00, 1'b1);
		send_cmd(CMD_WRITE, 8'hFF, 8'hFF, 1'b0);
		settle();

		configure(16'd256, 16'd256, 16'hFFFF);
		send_cmd(CMD_WRITE, 8'd0, 8'd0, 1'b1);
		send_cmd(CMD_WRITE, 8'd1, 8'd0, 1'b1);
		send_cmd(CMD_WRITE, 8'd0, 8'd1, 1'b1);
		send_cmd(CMD_WRITE, 8'd1, 8'd1, 1'b1);
		send_cmd(CMD_START, 8'h55, 8'hAA, 1'b0);
		repeat (6) send_cmd(CMD_STEP, 8'hAA, 8'h55, 1'b1);
		settle();

		// Zero sizes clamp to one pixel and a zero limit acts as one.
		configure(16'd0, 16'd0, 16'd0);
		cur_w = 1;
		cur_h = 1;
		send_cmd(CMD_WRITE, 8'd0, 8'd0, 1'b1);
		send_cmd(CMD_WRITE, 8'd1, 8'd0, 1'b1);
		send_cmd(CMD_START, 8'd0, 8'd0, 1'b0);
		repeat (2) send_cmd(CMD_STEP, 8'd0, 8'd0, 1'b0);
		settle();

		configure(16'hFFFF, 16'd300, 16'd40);
		cur_w = 256;
		cur_h = 256;
		send_cmd(CMD_START, 8'd3, 8'd7, 1'b1);
		repeat (3) send_cmd(CMD_STEP, 8'd7, 8'd3, 1'b0);

		while (items < ITEM_TARGET) begin
			settle();
			w = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
			h = ($urandom_range(0, 7) == 0) ? 1 : $urandom_range(2, 12);
			if ($urandom_range(0, 9) == 0)
				w = $urandom_range(13, 40);
			case ($urandom_range(0, 7))
				0: lim = 16'd0;
				1: lim = 16'd1;
				2: lim = 16'($urandom_range(2, 12));
				default: lim = 16'($urandom_range(50, 600));
			endcase
			w_data = 16'(w);
			h_data = 16'(h);
			if ($urandom_range(0, 3) == 0) begin
				w_data[15:9] = 7'($urandom);
				h_data[15:9] = 7'($urandom);
			end
			configure(w_data, h_data, lim);
			cur_w = w;
			cur_h = h;
			rx_mode <= rx_mode_t'($urandom_range(0, 3));
			tx_bursty = ($urandom_range(0, 3) != 0);
			if (phase == 2) begin
				hold_toggle <= ~hold_toggle;
				tx_bursty = 1'b0;
			end
			repeat ($urandom_range(1, 4)) begin
				x0 = $urandom_range(0, cur_w - 1);
				y0 = $urandom_range(0, cur_h - 1);
				rw = $urandom_range(1, (cur_w - x0 < 4) ? cur_w - x0 : 4);
				rh = $urandom_range(1, (cur_h - y0 < 4) ? cur_h - y0 : 4);
				for (yy = y0; yy < y0 + rh; yy++)
					for (xx = x0; xx < x0 + rw; xx++)
						send_cmd(CMD_WRITE, 8'(xx), 8'(yy), 1'b1);
				repeat ($urandom_range(0, 4))
					send_cmd(CMD_WRITE, 8'($urandom_range(0, cur_w - 1)),
						8'($urandom_range(0, cur_h - 1)), 1'($urandom));
				if ($urandom_range(0, 3) == 0)
					send_cmd(CMD_WRITE, 8'($urandom), 8'($urandom), 1'($urandom));
				send_cmd(CMD_START, 8'($urandom), 8'($urandom), 1'($urandom));
				repeat ($urandom_range(1, 2 * (rw + rh) + 6)) begin
					pick = $urandom_range(0, 19);
					if (pick == 0)
						send_cmd(CMD_WRITE, 8'($urandom_range(0, cur_w - 1)),
							8'($urandom_range(0, cur_h - 1)), 1'($urandom));
					else if (pick == 1)
						send_cmd(CMD_START, 8'($urandom), 8'($urandom), 1'($urandom));
					else if (pick == 2)
						send_cmd(CMD_NOISE, 8'($urandom), 8'($urandom), 1'($urandom));
					else
						send_cmd(CMD_STEP, 8'($urandom), 8'($urandom), 1'($urandom));
				end
				if ($urandom_range(0, 1) == 0) begin
					for (yy = y0; yy < y0 + rh; yy++)
						for (xx = x0; xx < x0 + rw; xx++)
							send_cmd(CMD_WRITE, 8'(xx), 8'(yy), 1'b0);
				end
			end
			phase++;
		end

		settle();
		repeat (32) @(posedge clk);
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// File: files.f
rtl/mct_pkg.sv
rtl/moore_contour_tracer.sv
sim/contour_checker.sv
sim/tb.sv
